/* rtl/mnmq_pkg.sv */
// Shared types and constants for the MIDI note message queue.
// No dependencies; every rtl module imports this package.
`timescale 1ns / 1ps

package mnmq_pkg;

    localparam int CAPACITY_DEF = 63;

    // MIDI status bases and byte masks
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] CHAN_MASK       = 8'h0F;
    localparam logic [7:0] DATA_MASK       = 8'h7F;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_SERVICE  = 2'd2,
        OP_TX_DONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_STORE   = 2'd0,
        CMD_SERVICE = 2'd1,
        CMD_TX_DONE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  velocity;
    } cmd_t;

    // front end -> queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    // queue -> back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

/* rtl/mnmq_front.sv */
// Front end: takes a beat from the command port, decodes the op and
// builds the MIDI message bytes. Depends on mnmq_pkg.
`timescale 1ns / 1ps

module mnmq_front
    import mnmq_pkg::*;
(
    input  logic       start,
    input  logic [1:0] op,
    input  logic [7:0] channel,
    input  logic [7:0] note,
    input  logic [7:0] velocity,
    input  logic       full,
    output q_wr_t      wr
);

    logic [7:0] chan_masked;
    logic [7:0] note_masked;
    logic [7:0] vel_masked;

    always_comb
    begin
        chan_masked = channel & CHAN_MASK;
        note_masked = note & DATA_MASK;
        vel_masked  = velocity & DATA_MASK;

        wr.push         = start && !full;
        wr.cmd.note     = note_masked[6:0];
        wr.cmd.velocity = vel_masked[6:0];
        wr.cmd.status   = '0;
        wr.cmd.kind     = CMD_STORE;

        unique case (op_t'(op))
            OP_NOTE_ON:
            begin
                wr.cmd.kind   = CMD_STORE;
                wr.cmd.status = STATUS_NOTE_ON | chan_masked;
            end
            OP_NOTE_OFF:
            begin
                wr.cmd.kind   = CMD_STORE;
                wr.cmd.status = STATUS_NOTE_OFF | chan_masked;
            end
            OP_SERVICE:
            begin
                wr.cmd.kind = CMD_SERVICE;
            end
            OP_TX_DONE:
            begin
                wr.cmd.kind = CMD_TX_DONE;
            end
            default:
            begin
                wr.cmd.kind = CMD_STORE;
            end
        endcase
    end

endmodule

/* rtl/mnmq_cmd_queue.sv */
// Two-entry command queue that decouples the front end from the back end.
// Depends on mnmq_pkg.
`timescale 1ns / 1ps

module mnmq_cmd_queue
    import mnmq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t wr,
    input  logic  pop,
    output q_rd_t rd,
    output logic  full
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entries_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        unique case ({wr.push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd.valid = (count_reg != '0);
    assign rd.cmd   = entries_reg[rd_ptr_reg];
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr.push)
        else $error("command queue overflow");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd.valid)
        else $error("command queue underflow");
`endif

endmodule

/* rtl/mnmq_back.sv */
// Back end: message store, write/unsent counters and the transfer flag.
// Carries out one queued command per cycle. Depends on mnmq_pkg.
`timescale 1ns / 1ps

module mnmq_back
    import mnmq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_rd_t      rd,
    output logic       pop,
    output logic       done,
    output logic       send_valid,
    output logic [7:0] status_byte,
    output logic [6:0] first_data,
    output logic [6:0] second_data,
    output logic       accepted,
    output logic       in_flight,
    output logic [5:0] waiting
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [23:0]      store_reg [CAPACITY];
    logic [23:0]      rd_data_reg;

    logic [CNT_W-1:0] wi_reg;
    logic [CNT_W-1:0] wi_next;
    logic [CNT_W-1:0] unsent_reg;
    logic [CNT_W-1:0] unsent_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic             send_valid_reg;
    logic             send_valid_next;
    logic             accepted_reg;
    logic             accepted_next;

    logic             do_write;
    logic             do_send;
    logic [CNT_W-1:0] pos;
    logic [23:0]      msg;
    logic [CNT_W+5:0] waiting_wide;

    assign pos = wi_reg - unsent_reg;
    assign msg = {rd.cmd.status, 1'b0, rd.cmd.note, 1'b0, rd.cmd.velocity};

    always_comb
    begin
        wi_next         = wi_reg;
        unsent_next     = unsent_reg;
        busy_next       = busy_reg;
        done_next       = rd.valid;
        send_valid_next = 1'b0;
        accepted_next   = 1'b0;
        do_write        = 1'b0;
        do_send         = 1'b0;

        if (rd.valid)
        begin
            unique case (rd.cmd.kind)
                CMD_STORE:
                begin
                    if (wi_reg < CAP_C)
                    begin
                        do_write      = 1'b1;
                        accepted_next = 1'b1;
                        wi_next       = wi_reg + CNT_W'(1);
                        unsent_next   = unsent_reg + CNT_W'(1);
                    end
                end
                CMD_SERVICE:
                begin
                    do_send = (unsent_reg != '0) && !busy_reg;
                end
                CMD_TX_DONE:
                begin
                    if (unsent_reg != '0)
                    begin
                        do_send = 1'b1;
                    end
                    else
                    begin
                        wi_next   = '0;
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    do_send = 1'b0;
                end
            endcase
        end

        if (do_send)
        begin
            send_valid_next = 1'b1;
            unsent_next     = unsent_reg - CNT_W'(1);
            busy_next       = 1'b1;
        end
    end

    // message store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_reg[wi_reg[ADDR_W-1:0]] <= msg;
        end
        if (do_send)
        begin
            rd_data_reg <= store_reg[pos[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg         <= '0;
            unsent_reg     <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            send_valid_reg <= 1'b0;
            accepted_reg   <= 1'b0;
        end
        else
        begin
            wi_reg         <= wi_next;
            unsent_reg     <= unsent_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            send_valid_reg <= send_valid_next;
            accepted_reg   <= accepted_next;
        end
    end

    assign waiting_wide = {6'd0, unsent_reg};

    assign pop         = rd.valid;
    assign done        = done_reg;
    assign send_valid  = send_valid_reg;
    assign status_byte = send_valid_reg ? rd_data_reg[23:16] : 8'd0;
    assign first_data  = send_valid_reg ? rd_data_reg[14:8] : 7'd0;
    assign second_data = send_valid_reg ? rd_data_reg[6:0] : 7'd0;
    assign accepted    = accepted_reg;
    assign in_flight   = busy_reg;
    assign waiting     = waiting_wide[5:0];

`ifndef SYNTHESIS
    a_unsent_le_wi: assert property (@(posedge clk) disable iff (!rst_n)
        unsent_reg <= wi_reg)
        else $error("more unsent messages than stored ones");
    a_wi_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= CAP_C)
        else $error("write index past capacity");
    a_send_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && send_valid_reg) |-> busy_reg)
        else $error("message sent without transfer in flight");
    a_store_xor_send: assert property (@(posedge clk) disable iff (!rst_n)
        !(accepted_reg && send_valid_reg))
        else $error("one beat both stored and sent");
    a_result_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> done_reg)
        else $error("popped command gave no result");
`endif

endmodule

/* rtl/midi_note_message_queue.sv */
// MIDI note message queue. A beat accepted at one edge is held in the command
// queue and its result (done high) is registered in the back end; one beat per
// cycle is sustained. busy is the command queue full flag; the back end drains
// one beat each cycle, so the queue never fills and start can be held high.
// rst_n (async, active low) clears write index, unsent count, transfer flag
// and the queue; the message store is not cleared.
`timescale 1ns / 1ps

module midi_note_message_queue
    import mnmq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF   // message store depth, 1..63 (waiting is 6 bits wide)
)
(
    input  logic       clk,
    input  logic       rst_n,
    // command side
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [7:0] channel,
    input  logic [7:0] note,
    input  logic [7:0] velocity,
    // result side, one beat per command, strobed by done
    output logic       done,
    output logic       send_valid,
    output logic [7:0] status_byte,
    output logic [6:0] first_data,
    output logic [6:0] second_data,
    output logic       accepted,
    output logic       in_flight,
    output logic [5:0] waiting
);

    // Front end decodes and builds the message; the queue lets the back end
    // run on its own; the back end owns the store and all counters.
    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    // busy only reflects the queue; a new beat is taken whenever it has room
    assign busy = q_full;

    mnmq_front u_front (
        .start    (start),
        .op       (op),
        .channel  (channel),
        .note     (note),
        .velocity (velocity),
        .full     (q_full),
        .wr       (q_wr)
    );

    mnmq_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .rd    (q_rd),
        .full  (q_full)
    );

    // Back end: a note command writes the store at the write index when
    // there is room; service and transmit-done read the oldest unsent
    // entry (write index minus unsent count) into a read register that
    // feeds the result ports in the following cycle.
    mnmq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd          (q_rd),
        .pop         (q_pop),
        .done        (done),
        .send_valid  (send_valid),
        .status_byte (status_byte),
        .first_data  (first_data),
        .second_data (second_data),
        .accepted    (accepted),
        .in_flight   (in_flight),
        .waiting     (waiting)
    );

endmodule

/* dv/midi_note_message_queue_tb.sv */
// Testbench for midi_note_message_queue: random and directed note, service and
// transmit-done beats, each result checked against a built-in queue predictor.
// Depends on rtl/mnmq_pkg.sv and rtl/midi_note_message_queue.sv.
`timescale 1ns / 1ps

module midi_note_message_queue_tb;
    import mnmq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 1950;
    localparam int DRAIN_CYCLES = 10;

    // one result beat as the block should present it
    typedef struct {
        logic       send;
        logic [7:0] status;
        logic [6:0] note_b;
        logic [6:0] vel_b;
        logic       stored;
        logic       xfer;
        logic [5:0] unsent;
    } midi_result_t;

    // Mirror of the message queue: predicts one result per accepted beat and
    // checks the results in order.
    class note_queue_scoreboard;
        logic [23:0]  msg_store [CAPACITY_DEF];
        int unsigned  wr_idx;
        int unsigned  unsent_count;
        bit           xfer_active;
        midi_result_t pending_results[$];
        int           mismatches;

        // oldest unsent entry goes to the UART
        function void hand_over(ref midi_result_t r);
            logic [23:0] m;
            m = msg_store[wr_idx - unsent_count];
            r.send   = 1'b1;
            r.status = m[23:16];
            r.note_b = m[14:8];
            r.vel_b  = m[6:0];
            unsent_count--;
            xfer_active = 1'b1;
        endfunction

        function void note_beat(op_t kind, logic [7:0] ch, logic [7:0] nt,
                                logic [7:0] vel);
            midi_result_t r;
            logic [7:0]   stat;
            r = '{default: '0};
            case (kind)
                OP_NOTE_ON, OP_NOTE_OFF:
                begin
                    // full store drops the request silently
                    if (wr_idx < CAPACITY_DEF)
                    begin
                        stat = ((kind == OP_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF)
                               | (ch & CHAN_MASK);
                        msg_store[wr_idx] = {stat, nt & DATA_MASK, vel & DATA_MASK};
                        wr_idx++;
                        unsent_count++;
                        r.stored = 1'b1;
                    end
                end
                OP_SERVICE:
                begin
                    if (unsent_count > 0 && !xfer_active)
                        hand_over(r);
                end
                default:
                begin
                    // tx done: next message, or rewind the store when drained
                    if (unsent_count > 0)
                        hand_over(r);
                    else
                    begin
                        wr_idx = 0;
                        xfer_active = 1'b0;
                    end
                end
            endcase
            r.xfer   = xfer_active;
            r.unsent = unsent_count[5:0];
            pending_results.push_back(r);
        endfunction

        function void compare(string field, int unsigned exp_v, int unsigned act_v);
            if (exp_v !== act_v)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_beat(midi_result_t got);
            midi_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation pending");
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            compare("send_valid",  32'(exp_r.send),   32'(got.send));
            compare("status_byte", 32'(exp_r.status), 32'(got.status));
            compare("first_data",  32'(exp_r.note_b), 32'(got.note_b));
            compare("second_data", 32'(exp_r.vel_b),  32'(got.vel_b));
            compare("accepted",    32'(exp_r.stored), 32'(got.stored));
            compare("in_flight",   32'(exp_r.xfer),   32'(got.xfer));
            compare("waiting",     32'(exp_r.unsent), 32'(got.unsent));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    logic [7:0] channel;
    logic [7:0] note;
    logic [7:0] velocity;
    logic       done;
    logic       send_valid;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       accepted;
    logic       in_flight;
    logic [5:0] waiting;

    note_queue_scoreboard queue_sb = new();
    int  cycle_count = 0;
    int  beats_sent  = 0;
    bit  gaps_on     = 1'b1;

    midi_note_message_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .channel     (channel),
        .note        (note),
        .velocity    (velocity),
        .done        (done),
        .send_valid  (send_valid),
        .status_byte (status_byte),
        .first_data  (first_data),
        .second_data (second_data),
        .accepted    (accepted),
        .in_flight   (in_flight),
        .waiting     (waiting)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("midi_note_message_queue_tb NOT OK");
            $finish;
        end
    end

    // Result side: done marks a one-cycle beat, taken at the rising edge.
    // The receiver cannot stall, so every strobe is checked as it comes.
    always @(posedge clk)
    begin
        midi_result_t got;
        if (rst_n && done)
        begin
            got.send   = send_valid;
            got.status = status_byte;
            got.note_b = first_data;
            got.vel_b  = second_data;
            got.stored = accepted;
            got.xfer   = in_flight;
            got.unsent = waiting;
            queue_sb.check_beat(got);
        end
    end

    // Idle length after a beat: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Drive one command beat at the falling edge, hold it until an edge with
    // busy low takes it, then idle for a random gap. With no gap start stays
    // high straight into the next beat.
    task automatic issue_beat(op_t kind, logic [7:0] ch, logic [7:0] nt,
                              logic [7:0] vel);
        int gap;
        @(negedge clk);
        start    <= 1'b1;
        op       <= kind;
        channel  <= ch;
        note     <= nt;
        velocity <= vel;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        queue_sb.note_beat(kind, ch, nt, vel);
        beats_sent++;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // note request with random content; on or off picked at random
    task automatic random_note();
        issue_beat($urandom_range(0, 1) ? OP_NOTE_ON : OP_NOTE_OFF,
                   8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_cmd(op_t kind);
        issue_beat(kind, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int n;
        int drain_left;
        bit full_drain;

        start    = 1'b0;
        op       = OP_NOTE_ON;
        channel  = '0;
        note     = '0;
        velocity = '0;
        rst_n    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        issue_beat(OP_SERVICE, 8'h00, 8'h00, 8'h00);   // service with nothing stored
        issue_beat(OP_TX_DONE, 8'hFF, 8'hFF, 8'hFF);   // tx done while idle and empty
        issue_beat(OP_NOTE_ON, 8'hFF, 8'hFF, 8'hFF);   // all-ones fields get masked
        issue_beat(OP_NOTE_OFF, 8'h00, 8'h00, 8'h00);
        issue_beat(OP_NOTE_ON, 8'h5A, 8'h80, 8'h7F);
        issue_beat(OP_NOTE_OFF, 8'hF0, 8'h7F, 8'h80);
        issue_beat(OP_SERVICE, 8'h00, 8'h00, 8'h00);   // first message goes out
        issue_beat(OP_SERVICE, 8'h00, 8'h00, 8'h00);   // ignored while in flight
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);
        issue_beat(OP_NOTE_ON, 8'h0F, 8'h3C, 8'h40);   // append during a transfer
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);   // drained: store rewinds
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);   // done again, not in flight
        issue_beat(OP_NOTE_OFF, 8'h33, 8'h01, 8'h7E);
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);   // done starts a send unprompted
        issue_beat(OP_TX_DONE, 8'h00, 8'h00, 8'h00);

        // --- random part ---
        // Mostly well-formed sessions: a burst of notes, a service, then tx
        // dones. Some bursts overrun the store so requests get dropped, and
        // some sessions stop draining early so the store keeps filling.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70)
                                                : $urandom_range(1, 8);
                repeat (n) random_note();
                random_cmd(OP_SERVICE);
                full_drain = ($urandom_range(0, 2) != 0);
                drain_left = $urandom_range(0, 6);
                while (queue_sb.unsent_count > 0 && (full_drain || drain_left > 0))
                begin
                    if ($urandom_range(0, 5) == 0)
                        random_note();
                    random_cmd(OP_TX_DONE);
                    drain_left--;
                end
                if (full_drain)
                    random_cmd(OP_TX_DONE);   // final done rewinds the store
            end
            else
            begin
                // noise: any op with any content
                repeat ($urandom_range(1, 4))
                    issue_beat(op_t'($urandom_range(0, 3)), 8'($urandom),
                               8'($urandom), 8'($urandom));
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // every result must come back; the watchdog covers a hang
        while (queue_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (queue_sb.mismatches == 0)
            $display("midi_note_message_queue_tb OK");
        else
            $display("midi_note_message_queue_tb NOT OK");
        $finish;
    end

endmodule
